### hw/rtl/bst_pkg.sv
`default_nettype none

package bst_pkg;

  // largest channel count the polarity scan honors
  localparam int unsigned MAX_CHANNELS = 16;

  localparam int unsigned ADC_W      = 14;
  localparam int unsigned NUM_CH_W   = 5;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned TICK_W     = 6;
  localparam int unsigned CHAN_W     = 4;
  localparam int unsigned SCAN_CH_W  = TICK_W - 1;
  localparam int unsigned LAST_CH_W  = 6;

  localparam logic [NUM_CH_W-1:0] NUM_CHANNELS_RESET = NUM_CH_W'(16);

  // adc thresholds
  localparam logic signed [ADC_W-1:0] ADC_ZERO_LIM  = 14'sd5;
  localparam logic signed [ADC_W-1:0] ADC_FULL_SCALE = 14'sd8190;
  localparam logic signed [ADC_W-1:0] ADC_NEG_LIM   = -14'sd1000;
  localparam logic signed [ADC_W-1:0] ADC_OV_LIM    = 14'sd7500;

  // test steps
  localparam logic [STEP_W-1:0] STEP_ZERO  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SAT   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_POL_A = 3'd2;
  localparam logic [STEP_W-1:0] STEP_POL_B = 3'd3;

  // ticks of interest inside the zero and saturation steps
  localparam logic [TICK_W-1:0] TICK_ARM      = 6'd0;
  localparam logic [TICK_W-1:0] TICK_ZERO_CHK = 6'd1;
  localparam logic [TICK_W-1:0] TICK_SAT_CHK  = 6'd2;
  localparam logic [TICK_W-1:0] TICK_SAT_SEL  = 6'd3;
  localparam logic [TICK_W-1:0] TICK_SAT_END  = 6'd5;

  localparam logic [CHAN_W-1:0] SAT_CHANNEL = 4'd1;

  typedef enum logic [1:0] {
    RC_ONGOING = 2'd0,
    RC_SUCCESS = 2'd1,
    RC_FAILED  = 2'd2,
    RC_DONE    = 2'd3
  } result_e;

  typedef enum logic [1:0] {
    BAL_NONE = 2'd0,
    BAL_OFF  = 2'd1,
    BAL_CHG  = 2'd2,
    BAL_DCHG = 2'd3
  } balance_e;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [TICK_W-1:0] tick;
    logic              over_voltage;
    logic              scan_done;
    logic [CHAN_W-1:0] fail_ch;
  } state_t;

  typedef struct packed {
    result_e           rc;
    logic [STEP_W-1:0] step_now;
    logic              sel;
    logic [CHAN_W-1:0] chan;
    logic              mux_off;
    balance_e          bal;
    logic              start;
    logic [CHAN_W-1:0] err_ch;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/bst_step_logic.sv
`default_nettype none

module bst_step_logic (
  input  var bst_pkg::state_t                         state_i,
  input  wire logic signed [bst_pkg::ADC_W-1:0]       adc_i,
  input  wire logic [bst_pkg::NUM_CH_W-1:0]           num_channels_i,
  output bst_pkg::state_t                             state_o,
  output bst_pkg::result_t                            result_o
);

  localparam logic [bst_pkg::LAST_CH_W-1:0] MAX_CH =
    bst_pkg::LAST_CH_W'(bst_pkg::MAX_CHANNELS);

  logic [bst_pkg::LAST_CH_W-1:0] num_ext;
  logic [bst_pkg::LAST_CH_W-1:0] last_ch;
  logic [bst_pkg::SCAN_CH_W-1:0] scan_ch;
  bst_pkg::result_e              rc;
  bst_pkg::balance_e             bal;
  logic                          sel, mux_off, start;
  logic [bst_pkg::CHAN_W-1:0]    chan;
  logic                          ov_d, sc_d;
  logic [bst_pkg::CHAN_W-1:0]    fail_d;
  logic [bst_pkg::STEP_W-1:0]    step_d;
  logic [bst_pkg::TICK_W-1:0]    tick_d;

  // index of the last scanned channel, count clamped to one..max
  assign num_ext = bst_pkg::LAST_CH_W'(num_channels_i);
  always_comb begin
    if (num_ext == '0) begin
      last_ch = '0;
    end else if (num_ext > MAX_CH) begin
      last_ch = MAX_CH - 1'b1;
    end else begin
      last_ch = num_ext - 1'b1;
    end
  end

  assign scan_ch = state_i.tick[bst_pkg::TICK_W-1:1];

  always_comb begin
    rc      = bst_pkg::RC_ONGOING;
    bal     = bst_pkg::BAL_NONE;
    sel     = 1'b0;
    mux_off = 1'b0;
    start   = 1'b0;
    chan    = '0;
    ov_d    = state_i.over_voltage;
    sc_d    = state_i.scan_done;
    fail_d  = state_i.fail_ch;
    case (state_i.step)
      bst_pkg::STEP_ZERO: begin
        if (state_i.tick == bst_pkg::TICK_ARM) begin
          mux_off = 1'b1;
          bal     = bst_pkg::BAL_DCHG;
          start   = 1'b1;
        end else if (state_i.tick == bst_pkg::TICK_ZERO_CHK) begin
          rc = (adc_i > -bst_pkg::ADC_ZERO_LIM && adc_i < bst_pkg::ADC_ZERO_LIM)
             ? bst_pkg::RC_SUCCESS : bst_pkg::RC_FAILED;
        end
      end
      bst_pkg::STEP_SAT: begin
        if (state_i.tick == bst_pkg::TICK_ARM) begin
          mux_off = 1'b1;
          bal     = bst_pkg::BAL_CHG;
          start   = 1'b1;
        end else if (state_i.tick == bst_pkg::TICK_SAT_CHK) begin
          if (adc_i < bst_pkg::ADC_FULL_SCALE) rc = bst_pkg::RC_FAILED;
        end else if (state_i.tick == bst_pkg::TICK_SAT_SEL) begin
          sel     = 1'b1;
          chan    = bst_pkg::SAT_CHANNEL;
          mux_off = 1'b1;
          bal     = bst_pkg::BAL_CHG;
          start   = 1'b1;
        end else if (state_i.tick == bst_pkg::TICK_SAT_END) begin
          bal = bst_pkg::BAL_OFF;
          rc  = (adc_i < bst_pkg::ADC_FULL_SCALE) ? bst_pkg::RC_FAILED
                                                  : bst_pkg::RC_SUCCESS;
        end
      end
      bst_pkg::STEP_POL_A, bst_pkg::STEP_POL_B: begin
        if (state_i.over_voltage) begin
          rc = bst_pkg::RC_FAILED;
        end else if (state_i.scan_done) begin
          rc = bst_pkg::RC_SUCCESS;
        end else if (state_i.tick[0]) begin
          // odd tick: measure the selected cell
          mux_off = 1'b1;
          if (adc_i < bst_pkg::ADC_NEG_LIM) begin
            fail_d = scan_ch[bst_pkg::CHAN_W-1:0];
            rc     = bst_pkg::RC_FAILED;
          end else if (adc_i > bst_pkg::ADC_OV_LIM) begin
            ov_d   = 1'b1;
            fail_d = scan_ch[bst_pkg::CHAN_W-1:0];
            rc     = bst_pkg::RC_SUCCESS;
          end else if (bst_pkg::LAST_CH_W'(scan_ch) >= last_ch) begin
            sc_d = 1'b1;
            rc   = bst_pkg::RC_SUCCESS;
          end
        end else begin
          // even tick: select the cell and convert
          sel   = 1'b1;
          chan  = scan_ch[bst_pkg::CHAN_W-1:0];
          start = 1'b1;
        end
      end
      default: begin
        rc = bst_pkg::RC_DONE;
      end
    endcase
  end

  always_comb begin
    step_d = state_i.step;
    tick_d = state_i.tick;
    if (rc == bst_pkg::RC_SUCCESS) begin
      step_d = state_i.step + 1'b1;
      tick_d = '0;
    end else if (rc == bst_pkg::RC_ONGOING) begin
      tick_d = state_i.tick + 1'b1;
    end
  end

  assign state_o.step         = step_d;
  assign state_o.tick         = tick_d;
  assign state_o.over_voltage = ov_d;
  assign state_o.scan_done    = sc_d;
  assign state_o.fail_ch      = fail_d;

  assign result_o.rc       = rc;
  assign result_o.step_now = step_d;
  assign result_o.sel      = sel;
  assign result_o.chan     = chan;
  assign result_o.mux_off  = mux_off;
  assign result_o.bal      = bal;
  assign result_o.start    = start;
  assign result_o.err_ch   = fail_d;

endmodule

`default_nettype wire

### hw/rtl/bms_self_test_sequencer.sv
`default_nettype none

// channel   direction  handshake                 payload
// in        in         in_valid_i / in_stall_o   adc_sample_i
// out       out        out_valid_o / out_stall_i result_code_o .. error_channel_o
// cfg       in         cfg_valid_i / cfg_ready_o cfg_num_channels_i
//
// one item per clock sustained while out_stall_i is low; an accepted item passes through
// the input register, then the step decode and state update into the result register
// rst_ni clears the valids, the test state and the channel count (back to 16)
// out_stall_i holds a valid result register and, once the input register is full,
// raises in_stall_o in the same cycle; the config port is always ready

module bms_self_test_sequencer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // config write
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [bst_pkg::NUM_CH_W-1:0]        cfg_num_channels_i,
  // adc item in
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [bst_pkg::ADC_W-1:0]    adc_sample_i,
  // result item out
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [1:0]                               result_code_o,
  output logic [bst_pkg::STEP_W-1:0]               step_now_o,
  output logic                                     select_enable_o,
  output logic [bst_pkg::CHAN_W-1:0]               channel_index_o,
  output logic                                     mux_off_cmd_o,
  output logic [1:0]                               balance_cmd_o,
  output logic                                     start_conversion_o,
  output logic [bst_pkg::CHAN_W-1:0]               error_channel_o
);

  logic                             in_valid_q;
  logic signed [bst_pkg::ADC_W-1:0] adc_q;
  logic [bst_pkg::NUM_CH_W-1:0]     num_ch_q;
  bst_pkg::state_t                  state_q, state_d;
  bst_pkg::result_t                 res_q, res_d;
  logic                             out_valid_q;
  logic                             out_busy;
  logic                             advance;

  // result register cannot take a new item while its item is stalled
  assign out_busy    = out_valid_q && out_stall_i;
  assign advance     = in_valid_q && !out_busy;
  assign in_stall_o  = in_valid_q && out_busy;
  assign cfg_ready_o = 1'b1;

  // channel count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ch_q <= bst_pkg::NUM_CHANNELS_RESET;
    end else if (cfg_valid_i) begin
      num_ch_q <= cfg_num_channels_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      adc_q <= adc_sample_i;
    end
  end

  // step decode on the registered sample
  bst_step_logic u_step (
    .state_i        (state_q),
    .adc_i          (adc_q),
    .num_channels_i (num_ch_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  // test state moves only when its item goes into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_code_o      = res_q.rc;
  assign step_now_o         = res_q.step_now;
  assign select_enable_o    = res_q.sel;
  assign channel_index_o    = res_q.chan;
  assign mux_off_cmd_o      = res_q.mux_off;
  assign balance_cmd_o      = res_q.bal;
  assign start_conversion_o = res_q.start;
  assign error_channel_o    = res_q.err_ch;

endmodule

`default_nettype wire
